// ===== rtl/rvc_pkg.sv =====
// rvc_pkg: shared types and constants for the rvc compressibility classifier
// holds the rv32i opcode and funct codes and the compressed form class encoding
// no dependencies
`default_nettype none

package rvc_pkg;

    localparam int unsigned InstrWidth = 32;
    localparam int unsigned ClassWidth = 5;

    typedef logic [6:0] opcode_t;

    localparam opcode_t OpReg    = 7'd51;
    localparam opcode_t OpJalr   = 7'd103;
    localparam opcode_t OpImm    = 7'd19;
    localparam opcode_t OpLui    = 7'd55;
    localparam opcode_t OpLoad   = 7'd3;
    localparam opcode_t OpStore  = 7'd35;
    localparam opcode_t OpBranch = 7'd99;
    localparam opcode_t OpJal    = 7'd111;

    localparam logic [6:0] F7Zero = 7'd0;
    localparam logic [6:0] F7Alt  = 7'd32;

    localparam logic [2:0] F3Add  = 3'd0;
    localparam logic [2:0] F3Sll  = 3'd1;
    localparam logic [2:0] F3Word = 3'd2;
    localparam logic [2:0] F3Xor  = 3'd4;
    localparam logic [2:0] F3Srx  = 3'd5;
    localparam logic [2:0] F3Or   = 3'd6;
    localparam logic [2:0] F3And  = 3'd7;
    localparam logic [2:0] F3Beq  = 3'd0;
    localparam logic [2:0] F3Bne  = 3'd1;

    localparam logic [4:0] RegZero = 5'd0;
    localparam logic [4:0] RegRa   = 5'd1;
    localparam logic [4:0] RegSp   = 5'd2;

    typedef enum logic [ClassWidth-1:0] {
        FC_NONE   = 5'd0,
        FC_ADD    = 5'd1,
        FC_MV     = 5'd2,
        FC_JR     = 5'd3,
        FC_JALR   = 5'd4,
        FC_LI     = 5'd5,
        FC_LUI    = 5'd6,
        FC_ADDI   = 5'd7,
        FC_SLLI   = 5'd8,
        FC_LW     = 5'd9,
        FC_SW     = 5'd10,
        FC_AND    = 5'd11,
        FC_OR     = 5'd12,
        FC_XOR    = 5'd13,
        FC_SUB    = 5'd14,
        FC_BEQZ   = 5'd15,
        FC_BNEZ   = 5'd16,
        FC_SRLI   = 5'd17,
        FC_SRAI   = 5'd18,
        FC_ANDI   = 5'd19,
        FC_J      = 5'd20,
        FC_JAL    = 5'd21,
        FC_BRANCH = 5'd22,
        FC_JUMP   = 5'd23
    } form_t;

endpackage

`default_nettype wire

// ===== rtl/rvc_decode.sv =====
// rvc_decode: combinational priority classifier for one rv32i instruction word
// depends on rvc_pkg for opcodes, funct codes and the form class type
`default_nettype none

module rvc_decode (
    input  wire logic [rvc_pkg::InstrWidth-1:0] instr,
    output rvc_pkg::form_t                      form
);

    function automatic logic is_prime(input logic [4:0] r);
        is_prime = (r[4:3] == 2'b01);
    endfunction

    logic [6:0]  op;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [6:0]  f7;
    logic [11:0] imm12;
    logic [19:0] imm20;
    logic [11:0] soff;
    logic        reg_alu;
    logic        prime3;
    logic        imm12_fits6;
    logic        imm20_fits6;
    logic        lw_off_ok;
    logic        sw_off_ok;

    always_comb
    begin
        op      = instr[6:0];
        rd      = instr[11:7];
        f3      = instr[14:12];
        rs1     = instr[19:15];
        rs2     = instr[24:20];
        f7      = instr[31:25];
        imm12   = instr[31:20];
        imm20   = instr[31:12];
        soff    = {f7, rd};
        reg_alu = (op == rvc_pkg::OpReg);
        prime3  = is_prime(rs1) && is_prime(rs2) && (rs1 == rd);

        // signed range -32..31: upper bits all copies of the sign
        imm12_fits6 = (imm12[11:5] == 7'h00) || (imm12[11:5] == 7'h7F);
        imm20_fits6 = (imm20[19:5] == 15'h0000) || (imm20[19:5] == 15'h7FFF);

        // word-aligned offset up to 124
        lw_off_ok = (imm12[1:0] == 2'b00) && (imm12[11:7] == 5'd0);
        sw_off_ok = (soff[1:0] == 2'b00) && (soff[11:7] == 5'd0);

        if (reg_alu && rd != rvc_pkg::RegZero && rs2 != rvc_pkg::RegZero && rd == rs1
                && f3 == rvc_pkg::F3Add && f7 == rvc_pkg::F7Zero)
            form = rvc_pkg::FC_ADD;
        else if (reg_alu && rd != rvc_pkg::RegZero && rs2 != rvc_pkg::RegZero
                && rs1 == rvc_pkg::RegZero && f3 == rvc_pkg::F3Add && f7 == rvc_pkg::F7Zero)
            form = rvc_pkg::FC_MV;
        else if (op == rvc_pkg::OpJalr && rs1 != rvc_pkg::RegZero && rd == rvc_pkg::RegZero
                && f3 == rvc_pkg::F3Add && imm12 == 12'd0)
            form = rvc_pkg::FC_JR;
        else if (op == rvc_pkg::OpJalr && rs1 != rvc_pkg::RegZero && rd == rvc_pkg::RegRa
                && f3 == rvc_pkg::F3Add && imm12 == 12'd0)
            form = rvc_pkg::FC_JALR;
        else if (op == rvc_pkg::OpImm && rs1 == rvc_pkg::RegZero && rd != rvc_pkg::RegZero
                && f3 == rvc_pkg::F3Add && imm12_fits6)
            form = rvc_pkg::FC_LI;
        else if (op == rvc_pkg::OpLui && rd != rvc_pkg::RegZero && rd != rvc_pkg::RegSp
                && imm20 != 20'd0 && imm20_fits6)
            form = rvc_pkg::FC_LUI;
        else if (op == rvc_pkg::OpImm && rs1 == rd && rd != rvc_pkg::RegZero
                && f3 == rvc_pkg::F3Add && imm12 != 12'd0 && imm12_fits6)
            form = rvc_pkg::FC_ADDI;
        else if (op == rvc_pkg::OpImm && rs1 == rd && rd != rvc_pkg::RegZero
                && f3 == rvc_pkg::F3Sll && f7 == rvc_pkg::F7Zero)
            form = rvc_pkg::FC_SLLI;
        else if (op == rvc_pkg::OpLoad && is_prime(rd) && is_prime(rs1)
                && f3 == rvc_pkg::F3Word && lw_off_ok)
            form = rvc_pkg::FC_LW;
        else if (op == rvc_pkg::OpStore && f3 == rvc_pkg::F3Word && is_prime(rs1)
                && is_prime(rs2) && sw_off_ok)
            form = rvc_pkg::FC_SW;
        else if (reg_alu && f7 == rvc_pkg::F7Zero && f3 == rvc_pkg::F3And && prime3)
            form = rvc_pkg::FC_AND;
        else if (reg_alu && f7 == rvc_pkg::F7Zero && f3 == rvc_pkg::F3Or && prime3)
            form = rvc_pkg::FC_OR;
        else if (reg_alu && f7 == rvc_pkg::F7Zero && f3 == rvc_pkg::F3Xor && prime3)
            form = rvc_pkg::FC_XOR;
        else if (reg_alu && f7 == rvc_pkg::F7Alt && f3 == rvc_pkg::F3Add && prime3)
            form = rvc_pkg::FC_SUB;
        else if (op == rvc_pkg::OpBranch && f3 == rvc_pkg::F3Beq && is_prime(rs1)
                && rs2 == rvc_pkg::RegZero)
            form = rvc_pkg::FC_BEQZ;
        else if (op == rvc_pkg::OpBranch && f3 == rvc_pkg::F3Bne && is_prime(rs1)
                && rs2 == rvc_pkg::RegZero)
            form = rvc_pkg::FC_BNEZ;
        else if (op == rvc_pkg::OpImm && rs1 == rd && is_prime(rs1)
                && f3 == rvc_pkg::F3Srx && f7 == rvc_pkg::F7Zero)
            form = rvc_pkg::FC_SRLI;
        else if (op == rvc_pkg::OpImm && rs1 == rd && is_prime(rs1)
                && f3 == rvc_pkg::F3Srx && f7 == rvc_pkg::F7Alt)
            form = rvc_pkg::FC_SRAI;
        else if (op == rvc_pkg::OpImm && rs1 == rd && is_prime(rs1)
                && f3 == rvc_pkg::F3And && imm12_fits6)
            form = rvc_pkg::FC_ANDI;
        else if (op == rvc_pkg::OpJal && rd == rvc_pkg::RegZero)
            form = rvc_pkg::FC_J;
        else if (op == rvc_pkg::OpJal && rd == rvc_pkg::RegRa)
            form = rvc_pkg::FC_JAL;
        else if (op == rvc_pkg::OpBranch)
            form = rvc_pkg::FC_BRANCH;
        else if (op == rvc_pkg::OpJal)
            form = rvc_pkg::FC_JUMP;
        else
            form = rvc_pkg::FC_NONE;
    end

endmodule

`default_nettype wire

// ===== rtl/rvc_compressibility_classifier.sv =====
// rvc_compressibility_classifier: top level, input register, decode, result register
// depends on rvc_pkg and rvc_decode
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   instruction[31:0]
//   out      output     out_valid/out_stall form_class[4:0]
//
// one transaction per cycle sustained while out_stall is low
// the word is held in the input register, classified by one shallow compare tree,
// and the class is held in the result register
// reset clears both valid flags; payload registers are not reset
// when out_stall holds a full result register, the input register still takes one
// transaction, then in_stall rises until the result moves on
`default_nettype none

module rvc_compressibility_classifier (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [rvc_pkg::InstrWidth-1:0]  instruction,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [rvc_pkg::ClassWidth-1:0]  form_class
);

    logic                           in_valid_reg;
    logic [rvc_pkg::InstrWidth-1:0] instr_reg;
    logic                           out_valid_reg;
    rvc_pkg::form_t                 form_reg;
    rvc_pkg::form_t                 form_next;
    logic                           out_adv;
    logic                           in_take;

    rvc_decode u_decode (
        .instr (instr_reg),
        .form  (form_next)
    );

    assign out_adv   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !out_adv;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign form_class = form_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (out_adv)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            instr_reg <= instruction;
        if (in_valid_reg && out_adv)
            form_reg <= form_next;
    end

    a_in_capture : assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_valid_reg && instr_reg == $past(instruction))
        else $error("input register missed a transaction");

    a_in_hold : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_adv |=> in_valid_reg && $stable(instr_reg))
        else $error("input register lost a held word");

    a_out_load : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_adv |=> out_valid_reg && form_reg == $past(form_next))
        else $error("result register did not take the decoded class");

    a_no_stall_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> !in_stall)
        else $error("stall raised with an empty input register");

endmodule

`default_nettype wire

// ===== dv/rvc_form_checker.sv =====
`timescale 1ns / 100ps
// rvc_form_checker: watches both channels of the classifier, predicts the form class of
// every accepted instruction word and compares it with the result in arrival order
// depends on rvc_pkg
module rvc_form_checker
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_stall,
    input  wire logic [rvc_pkg::InstrWidth-1:0] instruction,
    input  wire logic                           out_valid,
    input  wire logic                           out_stall,
    input  wire logic [rvc_pkg::ClassWidth-1:0] form_class,
    output int                                  mismatches,
    output int                                  pending
);

    typedef struct packed {
        logic [rvc_pkg::InstrWidth-1:0] word;
        rvc_pkg::form_t                 form;
    } classified_word_t;

    classified_word_t expected_forms[$];
    int               error_count = 0;

    function automatic logic is_prime(input logic [4:0] r);
        return r >= 5'd8 && r <= 5'd15;
    endfunction

    function automatic logic fits_six(input logic signed [19:0] v);
        return v >= -20'sd32 && v <= 20'sd31;
    endfunction

    function automatic logic word_offset(input logic [11:0] off);
        return off[1:0] == 2'b00 && off <= 12'd127;
    endfunction

    function automatic rvc_pkg::form_t predict_form(input logic [rvc_pkg::InstrWidth-1:0] w);
        rvc_pkg::opcode_t op;
        logic [4:0]       rd;
        logic [4:0]       rs1;
        logic [4:0]       rs2;
        logic [2:0]       f3;
        logic [6:0]       f7;
        logic [11:0]      imm12;
        logic [11:0]      soff;
        logic [19:0]      imm20;
        logic             reg_alu;
        logic             prime3;
        op      = w[6:0];
        rd      = w[11:7];
        f3      = w[14:12];
        rs1     = w[19:15];
        rs2     = w[24:20];
        f7      = w[31:25];
        imm12   = w[31:20];
        imm20   = w[31:12];
        soff    = {f7, rd};
        reg_alu = op == rvc_pkg::OpReg;
        prime3  = is_prime(rs1) && is_prime(rs2) && is_prime(rd) && rs1 == rd;

        if (reg_alu && rd != rvc_pkg::RegZero && rs2 != rvc_pkg::RegZero && rd == rs1
            && f3 == rvc_pkg::F3Add && f7 == rvc_pkg::F7Zero)
            return rvc_pkg::FC_ADD;
        if (reg_alu && rd != rvc_pkg::RegZero && rs2 != rvc_pkg::RegZero
            && rs1 == rvc_pkg::RegZero && f3 == rvc_pkg::F3Add && f7 == rvc_pkg::F7Zero)
            return rvc_pkg::FC_MV;
        if (op == rvc_pkg::OpJalr && rs1 != rvc_pkg::RegZero && rd == rvc_pkg::RegZero
            && f3 == rvc_pkg::F3Add && imm12 == '0)
            return rvc_pkg::FC_JR;
        if (op == rvc_pkg::OpJalr && rs1 != rvc_pkg::RegZero && rd == rvc_pkg::RegRa
            && f3 == rvc_pkg::F3Add && imm12 == '0)
            return rvc_pkg::FC_JALR;
        if (op == rvc_pkg::OpImm && rs1 == rvc_pkg::RegZero && rd != rvc_pkg::RegZero
            && f3 == rvc_pkg::F3Add && fits_six($signed(imm12)))
            return rvc_pkg::FC_LI;
        if (op == rvc_pkg::OpLui && rd != rvc_pkg::RegZero && rd != rvc_pkg::RegSp
            && imm20 != '0 && fits_six($signed(imm20)))
            return rvc_pkg::FC_LUI;
        if (op == rvc_pkg::OpImm && rs1 == rd && rd != rvc_pkg::RegZero
            && f3 == rvc_pkg::F3Add && imm12 != '0 && fits_six($signed(imm12)))
            return rvc_pkg::FC_ADDI;
        if (op == rvc_pkg::OpImm && rs1 == rd && rd != rvc_pkg::RegZero
            && f3 == rvc_pkg::F3Sll && f7 == rvc_pkg::F7Zero)
            return rvc_pkg::FC_SLLI;
        if (op == rvc_pkg::OpLoad && is_prime(rd) && is_prime(rs1) && f3 == rvc_pkg::F3Word
            && word_offset(imm12))
            return rvc_pkg::FC_LW;
        if (op == rvc_pkg::OpStore && f3 == rvc_pkg::F3Word && is_prime(rs1) && is_prime(rs2)
            && word_offset(soff))
            return rvc_pkg::FC_SW;
        if (reg_alu && f7 == rvc_pkg::F7Zero && f3 == rvc_pkg::F3And && prime3)
            return rvc_pkg::FC_AND;
        if (reg_alu && f7 == rvc_pkg::F7Zero && f3 == rvc_pkg::F3Or && prime3)
            return rvc_pkg::FC_OR;
        if (reg_alu && f7 == rvc_pkg::F7Zero && f3 == rvc_pkg::F3Xor && prime3)
            return rvc_pkg::FC_XOR;
        if (reg_alu && f7 == rvc_pkg::F7Alt && f3 == rvc_pkg::F3Add && prime3)
            return rvc_pkg::FC_SUB;
        if (op == rvc_pkg::OpBranch && f3 == rvc_pkg::F3Beq && is_prime(rs1)
            && rs2 == rvc_pkg::RegZero)
            return rvc_pkg::FC_BEQZ;
        if (op == rvc_pkg::OpBranch && f3 == rvc_pkg::F3Bne && is_prime(rs1)
            && rs2 == rvc_pkg::RegZero)
            return rvc_pkg::FC_BNEZ;
        if (op == rvc_pkg::OpImm && rs1 == rd && is_prime(rs1) && f3 == rvc_pkg::F3Srx
            && f7 == rvc_pkg::F7Zero)
            return rvc_pkg::FC_SRLI;
        if (op == rvc_pkg::OpImm && rs1 == rd && is_prime(rs1) && f3 == rvc_pkg::F3Srx
            && f7 == rvc_pkg::F7Alt)
            return rvc_pkg::FC_SRAI;
        if (op == rvc_pkg::OpImm && rs1 == rd && is_prime(rs1) && f3 == rvc_pkg::F3And
            && fits_six($signed(imm12)))
            return rvc_pkg::FC_ANDI;
        if (op == rvc_pkg::OpJal && rd == rvc_pkg::RegZero)
            return rvc_pkg::FC_J;
        if (op == rvc_pkg::OpJal && rd == rvc_pkg::RegRa)
            return rvc_pkg::FC_JAL;
        if (op == rvc_pkg::OpBranch)
            return rvc_pkg::FC_BRANCH;
        if (op == rvc_pkg::OpJal)
            return rvc_pkg::FC_JUMP;
        return rvc_pkg::FC_NONE;
    endfunction

    always @(posedge clk) begin
        classified_word_t oldest;
        if (rst_n) begin
            if (in_valid && !in_stall)
                expected_forms.push_back('{instruction, predict_form(instruction)});
            if (out_valid && !out_stall) begin
                if (expected_forms.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: unexpected form_class %0d with no transaction pending",
                                 $realtime, form_class);
                end
                else begin
                    oldest = expected_forms.pop_front();
                    if (form_class !== oldest.form) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("%0t: word %h form_class expected %0d (%s) got %0d",
                                     $realtime, oldest.word, oldest.form,
                                     oldest.form.name(), form_class);
                    end
                end
            end
            pending    <= expected_forms.size();
            mismatches <= error_count;
        end
    end

endmodule

// ===== dv/tb_rvc_compressibility_classifier.sv =====
`timescale 1ns / 100ps
// tb_rvc_compressibility_classifier: drives instruction words into the classifier with
// random idling and result stalls, and gives the verdict from rvc_form_checker
// depends on rvc_pkg, rvc_compressibility_classifier and rvc_form_checker
module tb_rvc_compressibility_classifier;

    localparam int RandomItems = 1225;
    localparam int CalmTail    = 150;
    localparam int QuietLimit  = 2000;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [rvc_pkg::InstrWidth-1:0] instruction;
    logic                           out_valid;
    logic                           out_stall;
    logic [rvc_pkg::ClassWidth-1:0] form_class;
    int                             mismatches;
    int                             pending;
    int                             quiet_cycles = 0;
    bit                             idle_on = 1'b1;

    rvc_compressibility_classifier dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .instruction (instruction),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .form_class  (form_class)
    );

    rvc_form_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .instruction (instruction),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .form_class  (form_class),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd, input rvc_pkg::opcode_t op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                          input logic [2:0] f3, input logic [4:0] rd,
                                          input rvc_pkg::opcode_t op);
        return {imm, rs1, f3, rd, op};
    endfunction

    // store and branch layout: offset split around the register fields
    function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input rvc_pkg::opcode_t op);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], op};
    endfunction

    function automatic logic [31:0] enc_u(input logic [19:0] imm, input logic [4:0] rd,
                                          input rvc_pkg::opcode_t op);
        return {imm, rd, op};
    endfunction

    function automatic logic [4:0] rand_reg();
        case ($urandom_range(0, 3))
            0:       return 5'($urandom_range(0, 2));
            1:       return 5'($urandom_range(8, 15));
            default: return 5'($urandom_range(0, 31));
        endcase
    endfunction

    function automatic logic [6:0] rand_f7();
        case ($urandom_range(0, 2))
            0:       return rvc_pkg::F7Zero;
            1:       return rvc_pkg::F7Alt;
            default: return 7'($urandom);
        endcase
    endfunction

    function automatic logic [11:0] rand_imm12();
        int v;
        case ($urandom_range(0, 2))
            0:       v = int'($urandom_range(0, 80)) - 40;
            1:       v = int'($urandom_range(0, 33)) * 4;
            default: v = int'($urandom);
        endcase
        return v[11:0];
    endfunction

    function automatic logic [31:0] random_instruction();
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [2:0]  f3;
        logic [11:0] imm;
        int          v;
        rd  = rand_reg();
        rs1 = $urandom_range(0, 1) ? rd : rand_reg();
        rs2 = rand_reg();
        f3  = 3'($urandom_range(0, 7));
        imm = rand_imm12();
        case ($urandom_range(0, 11))
            0, 1: begin
                if ($urandom_range(0, 2) == 0)
                    f3 = rvc_pkg::F3Add;
                return enc_r(rand_f7(), rs2, rs1, f3, rd, rvc_pkg::OpReg);
            end
            2: begin
                if ($urandom_range(0, 1))
                    imm = '0;
                if ($urandom_range(0, 1))
                    f3 = rvc_pkg::F3Add;
                if ($urandom_range(0, 1))
                    rd = 5'($urandom_range(0, 1));
                return enc_i(imm, rs1, f3, rd, rvc_pkg::OpJalr);
            end
            3, 4, 5: begin
                case ($urandom_range(0, 4))
                    0: f3 = rvc_pkg::F3Add;
                    1: f3 = rvc_pkg::F3Sll;
                    2: f3 = rvc_pkg::F3Srx;
                    3: f3 = rvc_pkg::F3And;
                    default: ;
                endcase
                if ($urandom_range(0, 1))
                    imm[11:5] = rand_f7();
                return enc_i(imm, rs1, f3, rd, rvc_pkg::OpImm);
            end
            6: begin
                v = $urandom_range(0, 1) ? int'($urandom_range(0, 80)) - 40 : int'($urandom);
                return enc_u(v[19:0], rd, rvc_pkg::OpLui);
            end
            7: return enc_i(imm, rs1, $urandom_range(0, 2) ? rvc_pkg::F3Word : f3, rd,
                            rvc_pkg::OpLoad);
            8: return enc_s(imm, rs2, rs1, $urandom_range(0, 2) ? rvc_pkg::F3Word : f3,
                            rvc_pkg::OpStore);
            9: begin
                case ($urandom_range(0, 2))
                    0: f3 = rvc_pkg::F3Beq;
                    1: f3 = rvc_pkg::F3Bne;
                    default: ;
                endcase
                if ($urandom_range(0, 1))
                    rs2 = rvc_pkg::RegZero;
                return enc_s(12'($urandom), rs2, rs1, f3, rvc_pkg::OpBranch);
            end
            10: begin
                if ($urandom_range(0, 2) != 0)
                    rd = 5'($urandom_range(0, 1));
                return enc_u(20'($urandom), rd, rvc_pkg::OpJal);
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [31:0] w);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge clk);
            in_valid    <= 1'b0;
            instruction <= $urandom;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        instruction <= w;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(negedge clk);
            end
            else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [31:0] directed_words[$];
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        instruction = '0;
        directed_words = '{
            32'h0000_0000,
            32'hFFFF_FFFF,
            enc_r(rvc_pkg::F7Zero, 5'd6, 5'd5, rvc_pkg::F3Add, 5'd5, rvc_pkg::OpReg),
            enc_r(rvc_pkg::F7Zero, 5'd6, rvc_pkg::RegZero, rvc_pkg::F3Add, 5'd5,
                  rvc_pkg::OpReg),
            enc_i(12'd0, 5'd5, rvc_pkg::F3Add, rvc_pkg::RegZero, rvc_pkg::OpJalr),
            enc_i(12'd0, 5'd31, rvc_pkg::F3Add, rvc_pkg::RegRa, rvc_pkg::OpJalr),
            enc_i(12'hFE0, rvc_pkg::RegZero, rvc_pkg::F3Add, 5'd5, rvc_pkg::OpImm),
            enc_u(20'hFFFE0, 5'd5, rvc_pkg::OpLui),
            enc_i(12'd31, 5'd5, rvc_pkg::F3Add, 5'd5, rvc_pkg::OpImm),
            enc_i(12'd32, 5'd5, rvc_pkg::F3Add, 5'd5, rvc_pkg::OpImm),
            enc_i(12'd0, 5'd31, rvc_pkg::F3Sll, 5'd31, rvc_pkg::OpImm),
            enc_i(12'd124, 5'd15, rvc_pkg::F3Word, 5'd8, rvc_pkg::OpLoad),
            enc_i(12'd128, 5'd15, rvc_pkg::F3Word, 5'd8, rvc_pkg::OpLoad),
            enc_s(12'd124, 5'd15, 5'd8, rvc_pkg::F3Word, rvc_pkg::OpStore),
            enc_r(rvc_pkg::F7Zero, 5'd9, 5'd8, rvc_pkg::F3And, 5'd8, rvc_pkg::OpReg),
            enc_r(rvc_pkg::F7Zero, 5'd15, 5'd14, rvc_pkg::F3Or, 5'd14, rvc_pkg::OpReg),
            enc_r(rvc_pkg::F7Zero, 5'd8, 5'd9, rvc_pkg::F3Xor, 5'd9, rvc_pkg::OpReg),
            enc_r(rvc_pkg::F7Alt, 5'd9, 5'd8, rvc_pkg::F3Add, 5'd8, rvc_pkg::OpReg),
            enc_s(12'hFFF, rvc_pkg::RegZero, 5'd8, rvc_pkg::F3Beq, rvc_pkg::OpBranch),
            enc_s(12'h000, rvc_pkg::RegZero, 5'd15, rvc_pkg::F3Bne, rvc_pkg::OpBranch),
            enc_i({rvc_pkg::F7Zero, 5'd0}, 5'd8, rvc_pkg::F3Srx, 5'd8, rvc_pkg::OpImm),
            enc_i({rvc_pkg::F7Alt, 5'd31}, 5'd9, rvc_pkg::F3Srx, 5'd9, rvc_pkg::OpImm),
            enc_i(12'hFE0, 5'd10, rvc_pkg::F3And, 5'd10, rvc_pkg::OpImm),
            enc_u(20'hFFFFF, rvc_pkg::RegZero, rvc_pkg::OpJal),
            enc_u(20'h00000, rvc_pkg::RegRa, rvc_pkg::OpJal),
            enc_s(12'h010, 5'd9, 5'd8, rvc_pkg::F3Beq, rvc_pkg::OpBranch),
            enc_u(20'h12345, 5'd5, rvc_pkg::OpJal)
        };

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_words[i])
            send_word(directed_words[i]);
        wait_for_results();

        for (int i = 0; i < RandomItems; i++) begin
            if (i == RandomItems / 2)
                wait_for_results();
            if (i == RandomItems - CalmTail)
                idle_on = 1'b0;
            send_word(random_instruction());
        end

        wait_for_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
